// ----- rtl/imu_scale_and_bias_calibration_top_macros.svh -----
// Assertion helpers for the IMU calibration block.
// Both expect clk and rst in scope.
`ifndef IMU_SCALE_AND_BIAS_CALIBRATION_TOP_MACROS_SVH
`define IMU_SCALE_AND_BIAS_CALIBRATION_TOP_MACROS_SVH

`ifndef ASSERT_OFF

`define AST_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("imu_sbc: same-cycle check failed");

`define AST_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("imu_sbc: next-cycle check failed");

`else

`define AST_IMPL(name, pre, post)

`define AST_NEXT(name, pre, post)

`endif

`endif

// ----- rtl/imu_sbc_pkg.sv -----
`timescale 1ns / 1ps

package imu_sbc_pkg;

  localparam int AXES        = 6;
  localparam int ACCEL_AXES  = 3;
  localparam int AXIS_W      = $clog2(AXES);
  localparam int AXIS_AZ     = 2;

  localparam int RAW_W       = 16;
  localparam int RAW_IW      = $clog2(RAW_W);
  localparam int OUT_W       = 32;
  localparam int SUM_W       = 48;
  localparam int DIFF_W      = OUT_W + 2;   // scaled (at most 28b signed) minus offset
  localparam int WIDE_W      = DIFF_W + 1;  // room for the 1 g correction
  localparam int QM_W        = OUT_W + 1;   // quotient magnitude, clamped to this width
  localparam int MEAN_W      = QM_W + 1;
  localparam int KW          = $clog2(SUM_W);
  localparam int SH_W        = KW;
  localparam int IDX_W       = KW + 1;

  localparam int FRACTION_BITS = 16;
  localparam int ACC_SH_BASE   = 1 + FRACTION_BITS - (RAW_W - 1);
  localparam int GYR_SH_BASE   = 4 + FRACTION_BITS - (RAW_W - 1);

  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int ARANGE_W    = 2;
  localparam int GRANGE_W    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RANGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_RANGE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_SAMPLES = 2'd2;

  localparam logic [ARANGE_W-1:0] ACCEL_RANGE_RST = 2'd2;
  localparam logic [GRANGE_W-1:0] GYRO_RANGE_RST  = 3'd5;
  localparam logic [CFG_W-1:0]    CAL_SAMPLES_RST = 16'd100;

  localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(2147483647);
  localparam logic signed [WIDE_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [WIDE_W-1:0] ONE_G  = WIDE_W'(1) << FRACTION_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_FINISH,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DIV_STORE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic add_en;
    logic off_we;
    logic sum_clr;
  } lane_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic item_stall;
    logic step;
    logic finish_go;
    logic div_start;
    logic store;
  } ctl_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [WIDE_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[OUT_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/imu_scale_and_bias_calibration_top.sv -----
// A beat accepted in idle is shifted bit-serially through the six lanes, then loaded
// into the result register once that register is free; no new item is taken until then.
// A calibration item that ends a run also holds off new items for six serial divisions.
// The bit-serial lane pass and the shared serial divider set this timing.
// Reset (rst, synchronous) zeroes offsets, sums and the count and restores registers.
`timescale 1ns / 1ps
`include "imu_scale_and_bias_calibration_top_macros.svh"

module imu_scale_and_bias_calibration_top #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [imu_sbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [imu_sbc_pkg::CFG_W-1:0]        cfg_data,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 operation,
  input  logic                                 sample_valid,
  input  logic signed [imu_sbc_pkg::RAW_W-1:0] accel_x_raw,
  input  logic signed [imu_sbc_pkg::RAW_W-1:0] accel_y_raw,
  input  logic signed [imu_sbc_pkg::RAW_W-1:0] accel_z_raw,
  input  logic signed [imu_sbc_pkg::RAW_W-1:0] gyro_x_raw,
  input  logic signed [imu_sbc_pkg::RAW_W-1:0] gyro_y_raw,
  input  logic signed [imu_sbc_pkg::RAW_W-1:0] gyro_z_raw,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic                                 result_ok,
  output logic signed [imu_sbc_pkg::OUT_W-1:0] accel_x_out,
  output logic signed [imu_sbc_pkg::OUT_W-1:0] accel_y_out,
  output logic signed [imu_sbc_pkg::OUT_W-1:0] accel_z_out,
  output logic signed [imu_sbc_pkg::OUT_W-1:0] gyro_x_out,
  output logic signed [imu_sbc_pkg::OUT_W-1:0] gyro_y_out,
  output logic signed [imu_sbc_pkg::OUT_W-1:0] gyro_z_out,
  output logic                                 calibration_done
);
  import imu_sbc_pkg::*;

  state_t                    state;
  state_t                    state_next;
  ctl_t                      ctl;

  logic [ARANGE_W-1:0]       accel_range;
  logic [GRANGE_W-1:0]       gyro_fs_sel;
  logic [CFG_W-1:0]          cal_samples;

  logic [COUNT_BITS-1:0]     count;
  logic [COUNT_BITS-1:0]     count_inc;
  logic [COUNT_BITS-1:0]     cmax;
  logic [COUNT_BITS-1:0]     target;
  logic                      done_now;

  logic                      op_q;
  logic                      ok_q;
  logic [KW-1:0]             bit_cnt;
  logic [AXIS_W-1:0]         axis;

  logic signed [SH_W-1:0]    sh_acc;
  logic signed [SH_W-1:0]    sh_gyr;
  logic signed [RAW_W-1:0]   raw_in [AXES];
  lane_ctrl_t                lane_ctrl [AXES];
  logic signed [DIFF_W-1:0]  diffs [AXES];
  logic signed [SUM_W-1:0]   sums [AXES];
  logic signed [OUT_W-1:0]   res_data [AXES];

  div_stat_t                 div_stat;
  logic signed [MEAN_W-1:0]  mean;
  logic signed [WIDE_W-1:0]  ofs_wide;
  logic signed [OUT_W-1:0]   ofs_sat;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_range <= ACCEL_RANGE_RST;
      gyro_fs_sel <= GYRO_RANGE_RST;
      cal_samples <= CAL_SAMPLES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACCEL_RANGE: accel_range <= cfg_data[ARANGE_W-1:0];
        CFG_GYRO_RANGE:  gyro_fs_sel <= cfg_data[GRANGE_W-1:0];
        CFG_CAL_SAMPLES: cal_samples <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sh_acc = $signed({{(SH_W-ARANGE_W){1'b0}}, accel_range}) + SH_W'(ACC_SH_BASE);
  assign sh_gyr = $signed({{(SH_W-GRANGE_W){1'b0}}, gyro_fs_sel}) + SH_W'(GYR_SH_BASE);

  assign raw_in[0] = accel_x_raw;
  assign raw_in[1] = accel_y_raw;
  assign raw_in[2] = accel_z_raw;
  assign raw_in[3] = gyro_x_raw;
  assign raw_in[4] = gyro_y_raw;
  assign raw_in[5] = gyro_z_raw;

  // run length, zero taken as one, clamped to the counter range
  always_comb begin
    cmax = '1;
    if (cal_samples == '0) begin
      target = COUNT_BITS'(1);
    end else if (cal_samples > CFG_W'(cmax)) begin
      target = cmax;
    end else begin
      target = cal_samples[COUNT_BITS-1:0];
    end
    count_inc = count + 1'b1;
    done_now  = op_q && ((count_inc == '0) || (count_inc >= target));
  end

  // FSM outputs
  always_comb begin
    ctl            = '0;
    ctl.item_stall = 1'b1;
    case (state)
      ST_IDLE:      ctl.item_stall = 1'b0;
      ST_SHIFT:     ctl.step       = 1'b1;
      ST_FINISH:    ctl.finish_go  = !result_valid || !result_stall;
      ST_DIV_START: ctl.div_start  = 1'b1;
      ST_DIV_WAIT:  ;
      ST_DIV_STORE: ctl.store      = 1'b1;
      default: ;
    endcase
  end

  assign item_stall = ctl.item_stall;

  // FSM next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (bit_cnt == KW'(SUM_W - 1)) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (ctl.finish_go) state_next = done_now ? ST_DIV_START : ST_IDLE;
      end
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_stat.done) state_next = ST_DIV_STORE;
      end
      ST_DIV_STORE: begin
        state_next = (axis == AXIS_W'(AXES - 1)) ? ST_IDLE : ST_DIV_START;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      bit_cnt      <= '0;
      axis         <= '0;
      count        <= '0;
      op_q         <= 1'b0;
      ok_q         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        bit_cnt <= '0;
        if (item_valid) begin
          op_q <= operation;
          ok_q <= sample_valid;
        end
      end else if (ctl.step) begin
        bit_cnt <= bit_cnt + 1'b1;
      end
      if (ctl.finish_go) begin
        axis <= '0;
        if (done_now) begin
          count <= '0;
        end else if (op_q) begin
          count <= count_inc;
        end
      end else if (ctl.store) begin
        axis <= axis + 1'b1;
      end
      if (ctl.finish_go) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.finish_go) begin
      result_ok        <= ok_q;
      calibration_done <= done_now;
      for (int i = 0; i < AXES; i++) begin
        res_data[i] <= ok_q ? sat_out(WIDE_W'(diffs[i])) : '0;
      end
    end
  end

  assign accel_x_out = res_data[0];
  assign accel_y_out = res_data[1];
  assign accel_z_out = res_data[2];
  assign gyro_x_out  = res_data[3];
  assign gyro_y_out  = res_data[4];
  assign gyro_z_out  = res_data[5];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      lane_ctrl[i].load    = (state == ST_IDLE) && item_valid;
      lane_ctrl[i].step    = ctl.step;
      lane_ctrl[i].add_en  = op_q && ok_q;
      lane_ctrl[i].off_we  = ctl.store && (axis == AXIS_W'(i));
      lane_ctrl[i].sum_clr = ctl.store && (axis == AXIS_W'(i));
    end
  end

  for (genvar i = 0; i < AXES; i++) begin : g_lane
    imu_sbc_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (lane_ctrl[i]),
      .k         (bit_cnt),
      .sh        ((i < ACCEL_AXES) ? sh_acc : sh_gyr),
      .raw       (raw_in[i]),
      .off_wdata (ofs_sat),
      .diff      (diffs[i]),
      .sum       (sums[i])
    );
  end

  imu_sbc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (sums[axis]),
    .divisor  (CFG_W'(target)),
    .stat     (div_stat),
    .mean     (mean)
  );

  // accel Z rests at 1 g, so its offset excludes gravity
  always_comb begin
    ofs_wide = WIDE_W'(mean);
    if (axis == AXIS_W'(AXIS_AZ)) begin
      ofs_wide = ofs_wide - ONE_G;
    end
    ofs_sat = sat_out(ofs_wide);
  end

  `AST_NEXT(a_accept_starts_pass, item_valid && !item_stall, (state == ST_SHIFT) && (bit_cnt == '0))
  `AST_IMPL(a_div_busy_in_wait, div_stat.busy, state == ST_DIV_WAIT)
  `AST_IMPL(a_store_after_div, state == ST_DIV_STORE, $past(div_stat.done))
  `AST_IMPL(a_invalid_zero, result_valid && !result_ok, (accel_x_out == '0) && (accel_y_out == '0) && (accel_z_out == '0) && (gyro_x_out == '0) && (gyro_y_out == '0) && (gyro_z_out == '0))

endmodule

// ----- rtl/imu_sbc_lane.sv -----
`timescale 1ns / 1ps

// One axis, bit-serial LSB first. Offset and sum rotate through their
// shift registers once per pass; the corrected value builds up in diff.
module imu_sbc_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  imu_sbc_pkg::lane_ctrl_t              ctrl,
  input  logic [imu_sbc_pkg::KW-1:0]           k,
  input  logic signed [imu_sbc_pkg::SH_W-1:0]  sh,
  input  logic signed [imu_sbc_pkg::RAW_W-1:0] raw,
  input  logic signed [imu_sbc_pkg::OUT_W-1:0] off_wdata,
  output logic signed [imu_sbc_pkg::DIFF_W-1:0] diff,
  output logic signed [imu_sbc_pkg::SUM_W-1:0] sum
);
  import imu_sbc_pkg::*;

  localparam logic signed [IDX_W-1:0] IDX_TOP = IDX_W'(RAW_W - 1);

  logic signed [RAW_W-1:0]  raw_q;
  logic signed [OUT_W-1:0]  off;
  logic signed [IDX_W-1:0]  idx;
  logic                     sbit;
  logic                     obit;
  logic                     dcarry;
  logic                     dcarry_next;
  logic                     d_cin;
  logic                     dbit;
  logic                     scarry;
  logic                     scarry_next;
  logic                     s_cin;
  logic                     abit;
  logic                     sum_bit;

  // bit k of raw scaled by 2^sh, sign extended, floor on right shifts
  always_comb begin
    idx = $signed({1'b0, k}) - $signed({sh[SH_W-1], sh});
    if (idx[IDX_W-1]) begin
      sbit = 1'b0;
    end else if (idx > IDX_TOP) begin
      sbit = raw_q[RAW_W-1];
    end else begin
      sbit = raw_q[idx[RAW_IW-1:0]];
    end
  end

  always_comb begin
    obit        = (k < KW'(OUT_W)) ? off[0] : off[OUT_W-1];
    d_cin       = (k == '0) ? 1'b1 : dcarry;
    dbit        = sbit ^ ~obit ^ d_cin;
    dcarry_next = (sbit & ~obit) | (sbit & d_cin) | (~obit & d_cin);
    abit        = sbit & ctrl.add_en;
    s_cin       = (k == '0) ? 1'b0 : scarry;
    sum_bit     = sum[0] ^ abit ^ s_cin;
    scarry_next = (sum[0] & abit) | (sum[0] & s_cin) | (abit & s_cin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      off <= '0;
      sum <= '0;
    end else if (ctrl.off_we) begin
      off <= off_wdata;
      sum <= '0;
    end else if (ctrl.sum_clr) begin
      sum <= '0;
    end else if (ctrl.step) begin
      if (k < KW'(OUT_W)) begin
        off <= {off[0], off[OUT_W-1:1]};
      end
      sum <= {sum_bit, sum[SUM_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      raw_q <= raw;
    end
    if (ctrl.step) begin
      dcarry <= dcarry_next;
      scarry <= scarry_next;
      if (k < KW'(DIFF_W)) begin
        diff <= {dbit, diff[DIFF_W-1:1]};
      end
    end
  end

endmodule

// ----- rtl/imu_sbc_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, truncates toward zero.
module imu_sbc_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [imu_sbc_pkg::SUM_W-1:0]  dividend,
  input  logic [imu_sbc_pkg::CFG_W-1:0]         divisor,
  output imu_sbc_pkg::div_stat_t                stat,
  output logic signed [imu_sbc_pkg::MEAN_W-1:0] mean
);
  import imu_sbc_pkg::*;

  logic [SUM_W-1:0]         qsr;
  logic [CFG_W-1:0]         rem;
  logic [CFG_W:0]           trial;
  logic [CFG_W:0]           trial_sub;
  logic                     fits;
  logic                     neg;
  logic                     big;
  logic [KW-1:0]            cnt;
  logic signed [MEAN_W-1:0] mag_s;

  always_comb begin
    trial     = {rem, qsr[SUM_W-1]};
    trial_sub = trial - {1'b0, divisor};
    fits      = trial >= {1'b0, divisor};
    // a quotient this large saturates downstream anyway
    big       = |qsr[SUM_W-1:QM_W];
    mag_s     = $signed({1'b0, big ? {QM_W{1'b1}} : qsr[QM_W-1:0]});
    mean      = neg ? -mag_s : mag_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
      end else if (stat.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == KW'(SUM_W - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qsr <= dividend[SUM_W-1] ? -dividend : dividend;
      neg <= dividend[SUM_W-1];
      rem <= '0;
    end else if (stat.busy) begin
      qsr <= {qsr[SUM_W-2:0], fits};
      rem <= fits ? trial_sub[CFG_W-1:0] : trial[CFG_W-1:0];
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import imu_sbc_pkg::*;

  localparam int COUNT_BITS   = 16;
  localparam int COUNT_MAX    = (1 << COUNT_BITS) - 1;
  localparam int DRAIN_CYCLES = 420;      // one lane pass plus six serial divisions
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 300;

  localparam logic OP_MEASURE   = 1'b0;
  localparam logic OP_CALIBRATE = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic                       op;
    logic                       valid;
    logic [AXES-1:0][RAW_W-1:0] raw;    // ax, ay, az, gx, gy, gz
  } imu_sample_t;

  typedef struct packed {
    logic                       ok;
    logic [AXES-1:0][OUT_W-1:0] axis;
    logic                       done;
  } imu_result_t;

  logic clk;
  logic rst = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic item_valid   = 1'b0;
  logic item_stall;
  logic operation    = 1'b0;
  logic sample_valid = 1'b0;
  logic signed [RAW_W-1:0] accel_x_raw = '0;
  logic signed [RAW_W-1:0] accel_y_raw = '0;
  logic signed [RAW_W-1:0] accel_z_raw = '0;
  logic signed [RAW_W-1:0] gyro_x_raw  = '0;
  logic signed [RAW_W-1:0] gyro_y_raw  = '0;
  logic signed [RAW_W-1:0] gyro_z_raw  = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic result_ok;
  logic signed [OUT_W-1:0] accel_x_out, accel_y_out, accel_z_out;
  logic signed [OUT_W-1:0] gyro_x_out, gyro_y_out, gyro_z_out;
  logic calibration_done;

  imu_scale_and_bias_calibration_top #(.COUNT_BITS(COUNT_BITS)) DUT (.*);

  // model state
  logic [ARANGE_W-1:0] accel_range = ACCEL_RANGE_RST;
  logic [GRANGE_W-1:0] gyro_fs_sel = GYRO_RANGE_RST;
  logic [CFG_W-1:0]    cal_target  = CAL_SAMPLES_RST;
  longint      axis_sum  [AXES];
  longint      axis_bias [AXES];
  int unsigned cal_count = 0;

  imu_result_t corrected_queue[$];
  int  mismatches  = 0;
  int  items_sent  = 0;
  int  cycle_count = 0;
  bit  calm        = 1'b0;
  bit  hold_toggle = 1'b0;
  bit  hold_seen   = 1'b0;
  int  hold_left   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < AXES; i++) begin
      axis_sum[i]  = 0;
      axis_bias[i] = 0;
    end
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Outputs use the offsets in force before this beat; sums take the
  // scaled reading before correction.
  function automatic imu_result_t correct_and_calibrate(input imu_sample_t s);
    imu_result_t r;
    longint      scaled [AXES];
    longint      m;
    int          sh;
    int unsigned target;
    r.ok   = s.valid;
    r.done = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      sh = (i < ACCEL_AXES) ? ACC_SH_BASE + int'(accel_range) : GYR_SH_BASE + int'(gyro_fs_sel);
      scaled[i] = longint'($signed(s.raw[i])) * (longint'(1) << sh);
      r.axis[i] = s.valid ? OUT_W'(clamp32(scaled[i] - axis_bias[i])) : '0;
    end
    if (s.op == OP_CALIBRATE) begin
      target = cal_target;
      if (target == 0) target = 1;
      if (target > COUNT_MAX) target = COUNT_MAX;
      if (s.valid) begin
        for (int i = 0; i < AXES; i++) axis_sum[i] += scaled[i];
      end
      cal_count = (cal_count + 1) & COUNT_MAX;
      if (cal_count == 0 || cal_count >= target) begin
        for (int i = 0; i < AXES; i++) begin
          m = axis_sum[i] / longint'(target);
          if (i == AXIS_AZ) m -= longint'(1) << FRACTION_BITS;
          axis_bias[i] = clamp32(m);
          axis_sum[i]  = 0;
        end
        cal_count = 0;
        r.done = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [RAW_W-1:0] rand_raw();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  function automatic imu_sample_t make_sample(input logic op, input logic valid,
                                              input logic [RAW_W-1:0] fill);
    imu_sample_t s;
    s.op    = op;
    s.valid = valid;
    for (int i = 0; i < AXES; i++) s.raw[i] = fill;
    return s;
  endfunction

  function automatic imu_sample_t rand_sample(input logic op, input logic valid);
    imu_sample_t s;
    s.op    = op;
    s.valid = valid;
    for (int i = 0; i < AXES; i++) s.raw[i] = rand_raw();
    return s;
  endfunction

  // register writes happen only with the block drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ACCEL_RANGE: accel_range = val[ARANGE_W-1:0];
      CFG_GYRO_RANGE:  gyro_fs_sel = val[GRANGE_W-1:0];
      CFG_CAL_SAMPLES: cal_target  = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_sample(input imu_sample_t s);
    int gap;
    bit taken;
    gap = 0;
    if (!calm) begin
      while (gap < 12 && $urandom_range(99) < 36) gap++;
    end
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid   <= 1'b1;
    operation    <= s.op;
    sample_valid <= s.valid;
    accel_x_raw  <= s.raw[0];
    accel_y_raw  <= s.raw[1];
    accel_z_raw  <= s.raw[2];
    gyro_x_raw   <= s.raw[3];
    gyro_y_raw   <= s.raw[4];
    gyro_z_raw   <= s.raw[5];
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !item_stall;
      @(posedge clk);
    end
    corrected_queue.push_back(correct_and_calibrate(s));
    items_sent++;
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (corrected_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    imu_sample_t s;
    send_sample(make_sample(OP_MEASURE, 1'b1, 16'h7FFF));
    send_sample(make_sample(OP_MEASURE, 1'b1, 16'h8000));
    s = make_sample(OP_MEASURE, 1'b1, 16'h0000);
    s.raw[1] = 16'hFFFF;
    s.raw[2] = 16'h0001;
    s.raw[3] = 16'h8000;
    s.raw[4] = 16'h7FFF;
    send_sample(s);
    send_sample(rand_sample(OP_MEASURE, 1'b0));
    wait_idle();
  endtask

  // full run at the reset target of 100
  task automatic test_default_run();
    imu_sample_t s;
    logic [AXES-1:0][RAW_W-1:0] base;
    for (int i = 0; i < AXES; i++) base[i] = RAW_W'($urandom);
    for (int n = 0; n < CAL_SAMPLES_RST; n++) begin
      s.op    = OP_CALIBRATE;
      s.valid = ($urandom_range(9) != 0);
      for (int i = 0; i < AXES; i++) s.raw[i] = base[i] + RAW_W'($urandom_range(63)) - 16'd32;
      send_sample(s);
    end
    send_sample(rand_sample(OP_MEASURE, 1'b1));
    send_sample(rand_sample(OP_MEASURE, 1'b1));
    wait_idle();
  endtask

  task automatic test_range_extremes();
    write_reg(CFG_ACCEL_RANGE, 16'd0);
    write_reg(CFG_GYRO_RANGE, 16'd0);
    send_sample(make_sample(OP_MEASURE, 1'b1, 16'h7FFF));
    send_sample(make_sample(OP_MEASURE, 1'b1, 16'h8000));
    wait_idle();
    write_reg(CFG_ACCEL_RANGE, 16'd3);
    write_reg(CFG_GYRO_RANGE, 16'd7);
    send_sample(make_sample(OP_MEASURE, 1'b1, 16'h7FFF));
    send_sample(make_sample(OP_MEASURE, 1'b1, 16'h8000));
    wait_idle();
  endtask

  // invalid beat still counts toward the run; a target of zero acts as one
  task automatic test_short_runs();
    write_reg(CFG_CAL_SAMPLES, 16'd2);
    send_sample(make_sample(OP_CALIBRATE, 1'b1, 16'h8000));
    send_sample(rand_sample(OP_CALIBRATE, 1'b0));
    send_sample(make_sample(OP_MEASURE, 1'b1, 16'h7FFF));
    wait_idle();
    write_reg(CFG_CAL_SAMPLES, 16'd0);
    send_sample(make_sample(OP_CALIBRATE, 1'b1, 16'h7FFF));
    send_sample(make_sample(OP_MEASURE, 1'b1, 16'h0000));
    wait_idle();
  endtask

  // count already past a lowered target: next calibration beat ends the run
  task automatic test_count_limits();
    write_reg(CFG_CAL_SAMPLES, 16'hFFFF);
    repeat (3) send_sample(rand_sample(OP_CALIBRATE, 1'b1));
    wait_idle();
    write_reg(CFG_UNUSED, CFG_W'($urandom));
    write_reg(CFG_CAL_SAMPLES, 16'd2);
    send_sample(rand_sample(OP_CALIBRATE, 1'b1));
    send_sample(rand_sample(OP_MEASURE, 1'b1));
    wait_idle();
  endtask

  task automatic test_backpressure();
    calm = 1'b1;
    hold_toggle = ~hold_toggle;
    repeat (16) send_sample(rand_sample($urandom_range(1), 1'b1));
    wait_idle();
    calm = 1'b0;
  endtask

  task automatic test_random_mix();
    int          goal;
    int          phase;
    int          run_len;
    int unsigned target;
    int          r;
    imu_sample_t s;
    logic [AXES-1:0][RAW_W-1:0] base;
    goal  = items_sent + 450;
    phase = 0;
    while (items_sent < goal) begin
      calm = (phase == 5);
      if ($urandom_range(9) < 6) write_reg(CFG_ACCEL_RANGE, CFG_W'($urandom_range(3)));
      if ($urandom_range(9) < 6) write_reg(CFG_GYRO_RANGE, CFG_W'($urandom_range(7)));
      if ($urandom_range(9) < 1) write_reg(CFG_UNUSED, CFG_W'($urandom));
      if ($urandom_range(9) < 7) begin
        r = $urandom_range(99);
        if (r < 70)      write_reg(CFG_CAL_SAMPLES, CFG_W'($urandom_range(8, 1)));
        else if (r < 80) write_reg(CFG_CAL_SAMPLES, 16'd0);
        else if (r < 90) write_reg(CFG_CAL_SAMPLES, CFG_W'($urandom_range(32, 9)));
        else if (r < 95) write_reg(CFG_CAL_SAMPLES, 16'hFFFF);
        else             write_reg(CFG_CAL_SAMPLES, CFG_W'($urandom_range(65535, 33)));
      end
      target = (cal_target == 0) ? 1 : cal_target;
      if ($urandom_range(9) < 7 && target <= 32) begin
        // well-formed run: exactly enough calibration beats, then measurements
        for (int i = 0; i < AXES; i++) base[i] = rand_raw();
        run_len = (target > cal_count) ? target - cal_count : 1;
        for (int n = 0; n < run_len; n++) begin
          s.op    = OP_CALIBRATE;
          s.valid = ($urandom_range(9) != 0);
          for (int i = 0; i < AXES; i++) begin
            s.raw[i] = base[i] + RAW_W'($urandom_range(255)) - 16'd128;
          end
          send_sample(s);
        end
        repeat ($urandom_range(4, 1)) send_sample(rand_sample(OP_MEASURE, $urandom_range(9) != 0));
      end else begin
        repeat ($urandom_range(24, 8)) begin
          send_sample(rand_sample($urandom_range(1), $urandom_range(4) != 0));
        end
      end
      wait_idle();
      phase++;
    end
    calm = 1'b0;
  endtask

  // receiver: random stalls, or a counted hold-off when requested
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen    <= hold_toggle;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !calm && ($urandom_range(99) < 36);
    end
  end

  // outputs and stall are settled mid-cycle; the beat completes at the next edge
  always @(negedge clk) begin : result_check
    imu_result_t got;
    imu_result_t want;
    if (!rst && result_valid && !result_stall) begin
      got.ok      = result_ok;
      got.axis[0] = accel_x_out;
      got.axis[1] = accel_y_out;
      got.axis[2] = accel_z_out;
      got.axis[3] = gyro_x_out;
      got.axis[4] = gyro_y_out;
      got.axis[5] = gyro_z_out;
      got.done    = calibration_done;
      if (corrected_queue.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, ok=%b done=%b", $time, got.ok,
                 got.done);
      end else begin
        want = corrected_queue.pop_front();
        if (got.ok !== want.ok) begin
          mismatches++;
          $display("%0t: result_ok expected %b actual %b", $time, want.ok, got.ok);
        end
        for (int i = 0; i < AXES; i++) begin
          if (got.axis[i] !== want.axis[i]) begin
            mismatches++;
            $display("%0t: axis %0d expected %0d actual %0d", $time, i,
                     $signed(want.axis[i]), $signed(got.axis[i]));
          end
        end
        if (got.done !== want.done) begin
          mismatches++;
          $display("%0t: calibration_done expected %b actual %b", $time, want.done, got.done);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_default_run();
    test_range_extremes();
    test_short_runs();
    test_count_limits();
    test_backpressure();
    test_random_mix();
    wait_idle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
